// ----- rtl/core/ahrr_pkg.sv -----
// shared types and constants for the audio history ring with readers
package ahrr_pkg;

	localparam int SAMPLE_W = 16;
	localparam int RIDX_W   = 2;
	localparam int BACK_W   = 16;
	localparam int OVR_W    = 16;
	localparam int PEAK_W   = 16;
	localparam int COUNT_W  = 32;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_ATTACH = 2'd1,
		OP_READ   = 2'd2,
		OP_PEAK   = 2'd3
	} op_t;

	// strobes from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic lag;
		logic exec;
		logic load;
	} ctl_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic out_stall;
	} ctl_sts_t;

endpackage

// ----- rtl/core/ahrr_if.sv -----
// request and response channel interfaces
interface ahrr_in_if;
	import ahrr_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	logic [SAMPLE_W-1:0] sample_in;
	logic [RIDX_W-1:0]   reader_index;
	logic [BACK_W-1:0]   lookback;

	modport source(output valid, func, sample_in, reader_index, lookback, input ready);
	modport sink(input valid, func, sample_in, reader_index, lookback, output ready);
endinterface

interface ahrr_out_if;
	import ahrr_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_out;
	logic                sample_valid;
	logic                lapped;
	logic [OVR_W-1:0]    overrun_count;
	logic [PEAK_W-1:0]   peak_value;
	logic [COUNT_W-1:0]  written_count;

	modport source(output valid, sample_out, sample_valid, lapped, overrun_count,
		peak_value, written_count, input ready);
	modport sink(input valid, sample_out, sample_valid, lapped, overrun_count,
		peak_value, written_count, output ready);
endinterface

// ----- rtl/core/audio_history_ring_readers.sv -----
// top level: audio history ring with independent readers
//
//  channel  dir  modport       payload
//  req      in   ahrr_in_if    func, sample_in, reader_index, lookback
//  rsp      out  ahrr_out_if   sample_out, sample_valid, lapped, overrun_count,
//                              peak_value, written_count
//
// each word passes through capture, lag subtract, execute (one access of the
// single-port history store), then load into the output register
// one word is in flight at a time; one response word per request word
// reset clears the write count, peak, cursors and overrun counts at once; the
// store itself is not swept: a fill flag and the write count mask entries never
// written, which read as zero, so words are taken right after reset
// a response waiting on rsp does not block the next request from being taken;
// only a second finished result waits until the output register frees up
module audio_history_ring_readers import ahrr_pkg::*; #(
	parameter int HISTORY_DEPTH = 32768,
	parameter int NUM_READERS   = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	ahrr_in_if.sink           req,
	ahrr_out_if.source        rsp
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;
	logic     in_ready;

	// sequencing of capture, lag, execute and output load
	ahrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, counters, cursors and the output register
	ahrr_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.NUM_READERS   (NUM_READERS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (req.func),
		.sample_in     (req.sample_in),
		.reader_index  (req.reader_index),
		.lookback      (req.lookback),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.sample_out    (rsp.sample_out),
		.sample_valid  (rsp.sample_valid),
		.lapped        (rsp.lapped),
		.overrun_count (rsp.overrun_count),
		.peak_value    (rsp.peak_value),
		.written_count (rsp.written_count)
	);

	assign req.ready = in_ready;

endmodule

// ----- rtl/core/ahrr_ctrl.sv -----
// controller state machine sequencing one word through the datapath
module ahrr_ctrl import ahrr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LAG,
		S_EXEC,
		S_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_LAG;
				end
				S_LAG:  state_q <= S_EXEC;
				S_EXEC: state_q <= S_DONE;
				S_DONE: begin
					if (!sts.out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign cmd.capture = in_valid && (state_q == S_IDLE);
	assign cmd.lag     = (state_q == S_LAG);
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.load    = (state_q == S_DONE) && !sts.out_stall;

endmodule

// ----- rtl/core/ahrr_dp.sv -----
// datapath: history store, write count, peak, reader cursors and output register
module ahrr_dp import ahrr_pkg::*; #(
	parameter int HISTORY_DEPTH = 32768,
	parameter int NUM_READERS   = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_cmd_t            cmd,
	output ctl_sts_t            sts,
	input  logic [1:0]          func,
	input  logic [SAMPLE_W-1:0] sample_in,
	input  logic [RIDX_W-1:0]   reader_index,
	input  logic [BACK_W-1:0]   lookback,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] sample_out,
	output logic                sample_valid,
	output logic                lapped,
	output logic [OVR_W-1:0]    overrun_count,
	output logic [PEAK_W-1:0]   peak_value,
	output logic [COUNT_W-1:0]  written_count
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int RW = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
	localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(HISTORY_DEPTH);

	// captured word
	op_t                 op_q;
	logic [SAMPLE_W-1:0] smp_q;
	logic [RIDX_W-1:0]   ridx_q;
	logic [BACK_W-1:0]   back_q;

	// architectural state
	logic [COUNT_W-1:0]  wc_q;
	logic                full_q;
	logic [PEAK_W-1:0]   peak_q;
	logic [COUNT_W-1:0]  cur_q [NUM_READERS];
	logic [OVR_W-1:0]    ovr_q [NUM_READERS];
	logic [SAMPLE_W-1:0] mem   [HISTORY_DEPTH];

	// lag stage
	logic [COUNT_W-1:0]  lag_q;
	logic [COUNT_W-1:0]  cur_sel_q;
	logic [COUNT_W-1:0]  back_cl_q;
	logic                rok_q;

	// execute results
	logic                res_valid_q;
	logic                res_lap_q;
	logic [OVR_W-1:0]    res_ovr_q;
	logic [PEAK_W-1:0]   res_pk_q;
	logic                fill_ok_q;
	logic [SAMPLE_W-1:0] rdata_q;

	// output register
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_smp_q;
	logic                out_sv_q;
	logic                out_lap_q;
	logic [OVR_W-1:0]    out_ovr_q;
	logic [PEAK_W-1:0]   out_pk_q;
	logic [COUNT_W-1:0]  out_wc_q;

	logic [RW-1:0]       sel;
	logic                rok;
	logic [COUNT_W-1:0]  back32;
	logic [SAMPLE_W-1:0] mag;
	logic                rd_lap;
	logic                rd_hit;
	logic [COUNT_W-1:0]  rd_base;
	logic [OVR_W-1:0]    rd_ovr;
	logic [AW-1:0]       mem_addr;
	logic                mem_we;

	assign sel    = RW'(ridx_q);
	assign rok    = (COUNT_W'(ridx_q) < COUNT_W'(NUM_READERS));
	assign back32 = COUNT_W'(back_q);
	assign mag    = smp_q[SAMPLE_W-1] ? (~smp_q + SAMPLE_W'(1)) : smp_q;

	// read decisions use the registered lag
	assign rd_lap  = (lag_q > DEPTH_C);
	assign rd_hit  = rd_lap || (lag_q != '0);
	assign rd_base = rd_lap ? (wc_q - DEPTH_C) : cur_sel_q;
	assign rd_ovr  = (rd_lap && (ovr_q[sel] != '1)) ? (ovr_q[sel] + OVR_W'(1)) : ovr_q[sel];

	assign mem_we   = cmd.exec && (op_q == OP_WRITE);
	assign mem_addr = mem_we ? wc_q[AW-1:0] : rd_base[AW-1:0];

	// single-port store, no reset: unwritten entries are masked by the fill check
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= smp_q;
		end else begin
			rdata_q <= mem[mem_addr];
		end
	end

	// payload capture and lag stage
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op_t'(func);
			smp_q  <= sample_in;
			ridx_q <= reader_index;
			back_q <= lookback;
		end
		if (cmd.lag) begin
			cur_sel_q <= rok ? cur_q[sel] : '0;
			lag_q     <= wc_q - (rok ? cur_q[sel] : '0);
			back_cl_q <= (back32 > DEPTH_C) ? DEPTH_C : back32;
			rok_q     <= rok;
		end
	end

	// execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q        <= '0;
			full_q      <= 1'b0;
			peak_q      <= '0;
			res_valid_q <= 1'b0;
			res_lap_q   <= 1'b0;
			res_ovr_q   <= '0;
			res_pk_q    <= '0;
			fill_ok_q   <= 1'b0;
			for (int i = 0; i < NUM_READERS; i++) begin
				cur_q[i] <= '0;
				ovr_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			res_valid_q <= 1'b0;
			res_lap_q   <= 1'b0;
			res_ovr_q   <= '0;
			res_pk_q    <= '0;
			fill_ok_q   <= full_q || (rd_base[AW-1:0] < wc_q[AW-1:0]);
			case (op_q)
				OP_WRITE: begin
					wc_q <= wc_q + COUNT_W'(1);
					if (wc_q[AW-1:0] == {AW{1'b1}}) full_q <= 1'b1;
					if (mag > peak_q) peak_q <= mag;
				end
				OP_ATTACH: begin
					if (rok_q) begin
						cur_q[sel] <= wc_q - back_cl_q;
						ovr_q[sel] <= '0;
					end
				end
				OP_READ: begin
					if (rok_q) begin
						cur_q[sel]  <= rd_hit ? (rd_base + COUNT_W'(1)) : rd_base;
						ovr_q[sel]  <= rd_ovr;
						res_valid_q <= rd_hit;
						res_lap_q   <= rd_lap;
						res_ovr_q   <= rd_ovr;
					end
				end
				OP_PEAK: begin
					res_pk_q <= peak_q;
					peak_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_smp_q <= (res_valid_q && fill_ok_q) ? rdata_q : '0;
			out_sv_q  <= res_valid_q;
			out_lap_q <= res_lap_q;
			out_ovr_q <= res_ovr_q;
			out_pk_q  <= res_pk_q;
			out_wc_q  <= wc_q;
		end
	end

	assign sts.out_stall = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign sample_out    = out_smp_q;
	assign sample_valid  = out_sv_q;
	assign lapped        = out_lap_q;
	assign overrun_count = out_ovr_q;
	assign peak_value    = out_pk_q;
	assign written_count = out_wc_q;

	// a lapped read always delivers a sample
	a_lap_has_sample: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_lap_q || out_sv_q))
		else $error("lapped result without a sample");

	// no sample data on a result that delivered none
	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_sv_q) |-> (out_smp_q == '0))
		else $error("sample data on an empty result");

	// once the store has wrapped, it stays filled
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |=> full_q)
		else $error("fill flag dropped");

	// the output register is never overwritten while a result waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || out_ready))
		else $error("result overwritten while stalled");

endmodule

// ----- bench/ahrr_checker.sv -----
// checker that predicts and compares every response word of the history ring
`timescale 1ns / 100ps
module ahrr_checker import ahrr_pkg::*; #(
	parameter int HISTORY_DEPTH = 32768,
	parameter int NUM_READERS   = 4
) (
	input  logic clk,
	input  logic arst_n,
	ahrr_in_if   req,
	ahrr_out_if  rsp,
	output int   fail_count,
	output int   pending
);

	localparam logic [COUNT_W-1:0] DEPTH_N   = COUNT_W'(HISTORY_DEPTH);
	localparam logic [COUNT_W-1:0] SLOT_MASK = DEPTH_N - 1;
	localparam int                 REPORT_MAX = 10;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                sample_valid;
		logic                lapped;
		logic [OVR_W-1:0]    overruns;
		logic [PEAK_W-1:0]   peak;
		logic [COUNT_W-1:0]  written;
	} ring_word_t;

	// shadow copy of the ring and its readers
	logic [SAMPLE_W-1:0] ring_mem [HISTORY_DEPTH];
	logic [COUNT_W-1:0]  wr_count;
	logic [16:0]         peak_hold;
	logic [COUNT_W-1:0]  cursor [NUM_READERS];
	logic [OVR_W-1:0]    laps [NUM_READERS];
	ring_word_t          ring_words_due [$];

	function automatic ring_word_t apply_op(op_t op, logic [SAMPLE_W-1:0] smp,
		logic [RIDX_W-1:0] rd, logic [BACK_W-1:0] back);
		ring_word_t         res;
		logic [16:0]        mag;
		logic [COUNT_W-1:0] lag;
		logic [COUNT_W-1:0] span;
		res = '0;
		case (op)
		OP_WRITE: begin
			ring_mem[wr_count & SLOT_MASK] = smp;
			wr_count = wr_count + 1;
			mag = smp[SAMPLE_W-1] ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
			if (mag > peak_hold) begin
				peak_hold = mag;
			end
		end
		OP_ATTACH: begin
			if (int'(rd) < NUM_READERS) begin
				span = (COUNT_W'(back) > DEPTH_N) ? DEPTH_N : COUNT_W'(back);
				cursor[rd] = wr_count - span;
				laps[rd] = '0;
			end
		end
		OP_READ: begin
			if (int'(rd) < NUM_READERS) begin
				lag = wr_count - cursor[rd];
				// lapped: resume at the oldest sample still held
				if (lag > DEPTH_N) begin
					cursor[rd] = wr_count - DEPTH_N;
					lag = DEPTH_N;
					if (laps[rd] != '1) begin
						laps[rd] = laps[rd] + OVR_W'(1);
					end
					res.lapped = 1'b1;
				end
				if (lag != 0) begin
					res.sample = ring_mem[cursor[rd] & SLOT_MASK];
					res.sample_valid = 1'b1;
					cursor[rd] = cursor[rd] + 1;
				end
				res.overruns = laps[rd];
			end
		end
		default: begin
			res.peak = peak_hold[PEAK_W-1:0];
			peak_hold = '0;
		end
		endcase
		res.written = wr_count;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		ring_word_t want;
		ring_word_t got;
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				ring_mem[i] = '0;
			end
			for (int i = 0; i < NUM_READERS; i++) begin
				cursor[i] = '0;
				laps[i] = '0;
			end
			wr_count = '0;
			peak_hold = '0;
			ring_words_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// retire the response first: it always belongs to an older request
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.sample_out, rsp.sample_valid, rsp.lapped, rsp.overrun_count,
					rsp.peak_value, rsp.written_count};
				if (ring_words_due.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX) begin
						$display("%0t: response word with none outstanding: %p", $time, got);
					end
				end else begin
					want = ring_words_due.pop_front();
					if (got.sample !== want.sample || got.sample_valid !== want.sample_valid ||
						got.lapped !== want.lapped || got.overruns !== want.overruns ||
						got.peak !== want.peak || got.written !== want.written) begin
						fail_count++;
						if (fail_count <= REPORT_MAX) begin
							$display("%0t: mismatch expected %p", $time, want);
							$display("%0t:          actual   %p", $time, got);
						end
					end
				end
			end
			if (req.valid && req.ready) begin
				ring_words_due.push_back(apply_op(op_t'(req.func), req.sample_in,
					req.reader_index, req.lookback));
			end
			pending = ring_words_due.size();
		end
	end

endmodule

// ----- bench/audio_history_ring_readers_tb.sv -----
// top of the bench for the audio history ring: clock, reset, stimulus, verdict
`timescale 1ns / 100ps
module audio_history_ring_readers_tb;
	import ahrr_pkg::*;

	localparam int HISTORY_DEPTH = 32768;
	localparam int NUM_READERS   = 4;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_LIMIT   = 10000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	// calm: no idling on either side
	bit   calm = 1'b0;
	// long receiver hold-off request, picked up by the receiver process
	int   hold_cycles = 0;

	ahrr_in_if  req_ch();
	ahrr_out_if rsp_ch();

	audio_history_ring_readers #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.NUM_READERS  (NUM_READERS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	ahrr_checker #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.NUM_READERS  (NUM_READERS)
	) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the handshake hangs
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// receiver: random stall bursts, or a long hold-off when asked for one;
	// exactly one assignment to ready per loop pass, each pass on a new edge
	initial begin : receiver
		int n;
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
				rsp_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// random sample: mostly uniform, sometimes the extremes
	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
		0: return 16'h8000;
		1: return 16'h7fff;
		2: return 16'hffff;
		3: return 16'h0000;
		default: return SAMPLE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// offer one word and return at the edge that takes it; valid stays up
	// until the caller decides otherwise
	task automatic send_word(op_t op, logic [SAMPLE_W-1:0] smp, logic [RIDX_W-1:0] rd,
		logic [BACK_W-1:0] back);
		req_ch.valid        <= 1'b1;
		req_ch.func         <= op;
		req_ch.sample_in    <= smp;
		req_ch.reader_index <= rd;
		req_ch.lookback     <= back;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// sender idle burst between words
	task automatic sender_gap();
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// stop offering and wait until every outstanding word has come back;
	// wait for the clock edge first so the word taken at this edge is already counted
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// one random operation: writes and reads dominate so readers see real data,
	// attaches mostly use short lookbacks so reads land on fresh samples
	task automatic send_random();
		int                  pick;
		op_t                 op;
		logic [BACK_W-1:0]   back;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			op = OP_WRITE;
		end else if (pick < 80) begin
			op = OP_READ;
		end else if (pick < 90) begin
			op = OP_ATTACH;
		end else begin
			op = OP_PEAK;
		end
		case ($urandom_range(0, 19))
		0:       back = 16'hffff;
		1:       back = BACK_W'(HISTORY_DEPTH);
		2:       back = BACK_W'(HISTORY_DEPTH + 1);
		3:       back = BACK_W'(HISTORY_DEPTH - 1);
		4, 5, 6: back = BACK_W'($urandom_range(0, 65535));
		default: back = BACK_W'($urandom_range(0, 40));
		endcase
		send_word(op, rand_sample(), RIDX_W'($urandom_range(0, 3)), back);
		sender_gap();
	endtask

	initial begin : stimulus
		int guard;
		req_ch.valid        <= 1'b0;
		req_ch.func         <= OP_WRITE;
		req_ch.sample_in    <= '0;
		req_ch.reader_index <= '0;
		req_ch.lookback     <= '0;
		arst_n              <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty ring, reads of never-written slots, extreme samples
		send_word(OP_PEAK, 16'h0000, 2'd0, 16'd0);      // peak right after reset
		send_word(OP_READ, 16'hffff, 2'd0, 16'hffff);   // nothing pending
		send_word(OP_ATTACH, 16'h0000, 2'd1, 16'd5);    // lookback into empty store
		send_word(OP_READ, 16'h0000, 2'd1, 16'd0);      // returns a cleared slot
		send_word(OP_WRITE, 16'h7fff, 2'd0, 16'd0);
		send_word(OP_WRITE, 16'h8000, 2'd3, 16'hffff);  // most negative sample
		send_word(OP_WRITE, 16'h0000, 2'd0, 16'd0);
		send_word(OP_WRITE, 16'hffff, 2'd2, 16'h5555);
		send_word(OP_WRITE, 16'h0001, 2'd1, 16'haaaa);
		send_word(OP_PEAK, 16'h0000, 2'd0, 16'd0);      // peak of 32768
		send_word(OP_PEAK, 16'h0000, 2'd0, 16'd0);      // cleared by the last take
		send_word(OP_ATTACH, 16'h0000, 2'd2, 16'd0);    // attach at the newest
		send_word(OP_READ, 16'h0000, 2'd2, 16'd0);      // so nothing pending
		send_word(OP_ATTACH, 16'h0000, 2'd0, 16'hffff); // clamped to capacity
		send_word(OP_READ, 16'h0000, 2'd0, 16'd0);
		send_word(OP_ATTACH, 16'h0000, 2'd3, 16'd3);
		send_word(OP_READ, 16'h0000, 2'd3, 16'd0);
		send_word(OP_READ, 16'h0000, 2'd3, 16'd0);
		send_word(OP_READ, 16'h0000, 2'd3, 16'd0);
		send_word(OP_READ, 16'h0000, 2'd3, 16'd0);      // drained reader
		send_word(OP_ATTACH, 16'h0000, 2'd1, 16'd32768);
		send_word(OP_ATTACH, 16'h0000, 2'd1, 16'd32769);
		send_word(OP_WRITE, 16'h5555, 2'd1, 16'd0);
		send_word(OP_WRITE, 16'haaaa, 2'd2, 16'd0);
		send_word(OP_PEAK, 16'h0000, 2'd3, 16'd0);
		sender_gap();

		// random, with idling on both sides
		for (int k = 0; k < 600; k++) begin
			// long receiver hold-off while words keep coming: the block fills
			// and has to stall its input
			if (k == 250) begin
				hold_cycles = HOLD_CYCLES;
			end
			// sender pause until the ring has answered everything
			if (k == 450) begin
				wait_drained();
			end
			send_random();
		end

		// random again, no idling from here on: words back to back
		calm = 1'b1;
		for (int k = 0; k < 300; k++) begin
			send_random();
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (pending != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		// let anything unexpected still come out
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/ahrr_pkg.sv
rtl/core/ahrr_if.sv
rtl/core/ahrr_ctrl.sv
rtl/core/ahrr_dp.sv
rtl/core/audio_history_ring_readers.sv
bench/ahrr_checker.sv
bench/audio_history_ring_readers_tb.sv
